// ===== design/tkis_pkg.sv =====
// Shared constants, types and control codes for the top-k insertion selector.
// No dependencies; used by the interfaces, the cells, the remainder unit and the top level.
package tkis_pkg;

  localparam int MAX_KEEP_DEF    = 8;
  localparam int INDEX_WIDTH_DEF = 16;

  localparam int WEIGHT_W    = 32;
  localparam int DRAW_W      = 16;
  localparam int OUT_INDEX_W = 16;
  localparam int KEEP_CFG_W  = 4;

  localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = KEEP_CFG_W'(8);

  // remainder unit: restoring steps per clock and resulting cycle count
  localparam int REM_BITS_PER_CYCLE = 4;
  localparam int REM_CYCLES         = DRAW_W / REM_BITS_PER_CYCLE;
  localparam int REM_CNT_W          = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;

  typedef struct packed {
    logic cmp_en;     // latch compare flags against the pending weight
    logic ins_en;     // insert the pending item at the chosen slot
    logic shift_out;  // move every entry one slot toward the head
  } cell_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CMP  = 6'b000010,
    ST_CNT  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_INS  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

// ===== design/tkis_if.sv =====
// Handshake channels of the top-k insertion selector: scored item in, kept index out.
// Depends on tkis_pkg for field widths.
interface tkis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tkis_pkg::WEIGHT_W-1:0] weight;
  logic        [tkis_pkg::DRAW_W-1:0]   tie_draw;
  logic                                 last_item;

  modport source (output valid, weight, tie_draw, last_item, input ready);
  modport sink   (input valid, weight, tie_draw, last_item, output ready);
endinterface

interface tkis_out_if;
  logic                               valid;
  logic                               ready;
  logic [tkis_pkg::OUT_INDEX_W-1:0]   best_index;
  logic                               last_of_run;

  modport source (output valid, best_index, last_of_run, input ready);
  modport sink   (input valid, best_index, last_of_run, output ready);
endinterface

// ===== design/tkis_cell.sv =====
// One slot of the kept list: holds a weight and an index, compares against the pending item,
// and trades entries with its neighbors on insert and drain. Depends on tkis_pkg.
module tkis_cell #(
  parameter int SLOT        = 0,
  parameter int KW          = 4,
  parameter int INDEX_WIDTH = tkis_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  tkis_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [tkis_pkg::WEIGHT_W-1:0] new_weight_i,
  input  logic        [INDEX_WIDTH-1:0]        new_index_i,
  input  logic        [KW-1:0]                 slot_i,
  input  logic        [KW-1:0]                 used_i,
  input  logic signed [tkis_pkg::WEIGHT_W-1:0] prev_weight_i,
  input  logic        [INDEX_WIDTH-1:0]        prev_index_i,
  input  logic signed [tkis_pkg::WEIGHT_W-1:0] next_weight_i,
  input  logic        [INDEX_WIDTH-1:0]        next_index_i,
  output logic signed [tkis_pkg::WEIGHT_W-1:0] weight_o,
  output logic        [INDEX_WIDTH-1:0]        index_o,
  output logic                                 gt_o,
  output logic                                 ge_o
);

  localparam logic [KW-1:0] Pos = KW'(SLOT);

  logic signed [tkis_pkg::WEIGHT_W-1:0] weight_q;
  logic        [INDEX_WIDTH-1:0]        index_q;
  logic                                 gt_q;
  logic                                 ge_q;
  logic                                 in_use;

  assign in_use = Pos < used_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      gt_q <= in_use && (weight_q > new_weight_i);
      ge_q <= in_use && (weight_q >= new_weight_i);
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.ins_en && (Pos == slot_i)) begin
      weight_q <= new_weight_i;
      index_q  <= new_index_i;
    end else if (ctrl_i.ins_en && (Pos > slot_i)) begin
      weight_q <= prev_weight_i;
      index_q  <= prev_index_i;
    end else if (ctrl_i.shift_out) begin
      weight_q <= next_weight_i;
      index_q  <= next_index_i;
    end else begin
      weight_q <= weight_q;
      index_q  <= index_q;
    end
  end

  assign weight_o = weight_q;
  assign index_o  = index_q;
  assign gt_o     = gt_q;
  assign ge_o     = ge_q;

endmodule

// ===== design/tkis_rem.sv =====
// Multi-cycle remainder of the tie draw by the count of equal entries, restoring,
// several bits per clock. Depends on tkis_pkg.
module tkis_rem #(
  parameter int DW = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tkis_pkg::DRAW_W-1:0]   dividend_i,
  input  logic [DW-1:0]                 divisor_i,
  output logic                          busy_o,
  output logic [DW-1:0]                 rem_o
);

  logic [tkis_pkg::DRAW_W-1:0]  num_q, num_d;
  logic [DW-1:0]                rem_q, rem_d;
  logic [DW-1:0]                div_q;
  logic [tkis_pkg::REM_CNT_W-1:0] cnt_q;
  logic                         busy_q;

  always_comb begin
    logic [DW:0] t;
    num_d = num_q;
    rem_d = rem_q;
    for (int k = 0; k < tkis_pkg::REM_BITS_PER_CYCLE; k++) begin
      t     = {rem_d, num_d[tkis_pkg::DRAW_W-1]};
      num_d = {num_d[tkis_pkg::DRAW_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= tkis_pkg::REM_CNT_W'(tkis_pkg::REM_CYCLES - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/top_k_insertion_select_unit.sv =====
// Top level of the top-k insertion selector: sequencer, chain of list cells, remainder unit.
// Depends on tkis_pkg, tkis_if, tkis_cell and tkis_rem.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    weight, tie_draw, last_item
//   out_o     out  valid/ready    best_index, last_of_run
//   cfg       in   cfg_we_i       cfg_data_i (keep_count)
//
// An item goes through accept, compare, count and insert; with two or more equal entries the
// sequencer also waits in its divide state for the restoring remainder of the tie draw.
// A last item starts the drain through cell 0, one index per cycle while out_o is ready;
// out_o stalls simply hold the drain. Reset empties the list and zeroes the item counter;
// the cell contents need no reset. in_i is ready only while the sequencer is idle.
module top_k_insertion_select_unit #(
  parameter int MAX_KEEP    = tkis_pkg::MAX_KEEP_DEF,
  parameter int INDEX_WIDTH = tkis_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tkis_pkg::KEEP_CFG_W-1:0]   cfg_data_i,
  tkis_in_if.sink                           in_i,
  tkis_out_if.source                        out_o
);

  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam logic [INDEX_WIDTH-1:0] IndexMax = '1;

  tkis_pkg::state_e state_q, state_d;

  logic [tkis_pkg::KEEP_CFG_W-1:0] keep_q;
  logic [KW-1:0]                   fill_q, fill_d;
  logic [INDEX_WIDTH-1:0]          item_cnt_q, item_cnt_d;
  logic [KW-1:0]                   out_cnt_q, out_cnt_d;

  logic signed [tkis_pkg::WEIGHT_W-1:0] weight_q;
  logic        [tkis_pkg::DRAW_W-1:0]   draw_q;
  logic                                 last_q;
  logic        [INDEX_WIDTH-1:0]        index_q;
  logic        [KW-1:0]                 p_min_q;
  logic                                 tie_q;

  logic [KW-1:0] keep_eff;
  logic [KW-1:0] used;
  logic [KW-1:0] n_gt, n_ge, n_eq;
  logic [KW-1:0] slot;
  logic          fits;
  logic          in_acc, out_acc;
  logic          rem_start, rem_busy;
  logic [KW-1:0] rem;

  tkis_pkg::cell_ctrl_t ctrl;

  logic signed [tkis_pkg::WEIGHT_W-1:0] w_chain  [MAX_KEEP];
  logic        [INDEX_WIDTH-1:0]        idx_chain[MAX_KEEP];
  logic        [MAX_KEEP-1:0]           gt_vec, ge_vec;

  // keep_count of zero acts as one, above the list depth it saturates
  always_comb begin
    if (keep_q == '0) begin
      keep_eff = KW'(1);
    end else if (int'(keep_q) > MAX_KEEP) begin
      keep_eff = KW'(MAX_KEEP);
    end else begin
      keep_eff = KW'(keep_q);
    end
  end

  assign used = (fill_q < keep_eff) ? fill_q : keep_eff;

  always_comb begin
    n_gt = '0;
    n_ge = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      n_gt = n_gt + KW'(gt_vec[i]);
      n_ge = n_ge + KW'(ge_vec[i]);
    end
  end

  assign n_eq = n_ge - n_gt;
  assign slot = tie_q ? (p_min_q + rem) : p_min_q;
  assign fits = slot < keep_eff;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready        = (state_q == tkis_pkg::ST_IDLE);
  assign out_o.valid       = (state_q == tkis_pkg::ST_OUT);
  assign out_o.best_index  = tkis_pkg::OUT_INDEX_W'(idx_chain[0]);
  assign out_o.last_of_run = (out_cnt_q == KW'(1));

  assign rem_start      = (state_q == tkis_pkg::ST_CNT) && (n_eq > KW'(1));
  assign ctrl.cmp_en    = (state_q == tkis_pkg::ST_CMP);
  assign ctrl.ins_en    = (state_q == tkis_pkg::ST_INS) && fits;
  assign ctrl.shift_out = out_acc;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    item_cnt_d = item_cnt_q;
    out_cnt_d  = out_cnt_q;
    unique case (state_q)
      tkis_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = tkis_pkg::ST_CMP;
          if (item_cnt_q != IndexMax) begin
            item_cnt_d = item_cnt_q + 1'b1;
          end
        end
      end
      tkis_pkg::ST_CMP: state_d = tkis_pkg::ST_CNT;
      tkis_pkg::ST_CNT: state_d = rem_start ? tkis_pkg::ST_DIV : tkis_pkg::ST_INS;
      tkis_pkg::ST_DIV: begin
        if (!rem_busy) begin
          state_d = tkis_pkg::ST_INS;
        end
      end
      tkis_pkg::ST_INS: begin
        // lowering keep_count mid-set also trims the fill here
        fill_d = (fits && (used < keep_eff)) ? used + 1'b1 : used;
        if (last_q) begin
          state_d   = tkis_pkg::ST_OUT;
          out_cnt_d = fill_d;
        end else begin
          state_d = tkis_pkg::ST_IDLE;
        end
      end
      tkis_pkg::ST_OUT: begin
        if (out_acc) begin
          out_cnt_d = out_cnt_q - 1'b1;
          if (out_cnt_q == KW'(1)) begin
            state_d    = tkis_pkg::ST_IDLE;
            fill_d     = '0;
            item_cnt_d = '0;
          end
        end
      end
      default: state_d = tkis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tkis_pkg::ST_IDLE;
      keep_q     <= tkis_pkg::KEEP_RESET;
      fill_q     <= '0;
      item_cnt_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      item_cnt_q <= item_cnt_d;
      out_cnt_q  <= out_cnt_d;
      if (cfg_we_i) begin
        keep_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      weight_q <= in_i.weight;
      draw_q   <= in_i.tie_draw;
      last_q   <= in_i.last_item;
      index_q  <= item_cnt_q;
    end
    if (state_q == tkis_pkg::ST_CNT) begin
      p_min_q <= n_gt;
      tie_q   <= n_eq > KW'(1);
    end
  end

  tkis_rem #(
    .DW (KW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (draw_q),
    .divisor_i  (n_eq),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    logic signed [tkis_pkg::WEIGHT_W-1:0] prev_w, next_w;
    logic        [INDEX_WIDTH-1:0]        prev_idx, next_idx;

    if (g == 0) begin : g_head
      assign prev_w   = '0;
      assign prev_idx = '0;
    end else begin : g_body
      assign prev_w   = w_chain[g-1];
      assign prev_idx = idx_chain[g-1];
    end

    if (g == MAX_KEEP - 1) begin : g_tail
      assign next_w   = '0;
      assign next_idx = '0;
    end else begin : g_mid
      assign next_w   = w_chain[g+1];
      assign next_idx = idx_chain[g+1];
    end

    tkis_cell #(
      .SLOT        (g),
      .KW          (KW),
      .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_weight_i  (weight_q),
      .new_index_i   (index_q),
      .slot_i        (slot),
      .used_i        (used),
      .prev_weight_i (prev_w),
      .prev_index_i  (prev_idx),
      .next_weight_i (next_w),
      .next_index_i  (next_idx),
      .weight_o      (w_chain[g]),
      .index_o       (idx_chain[g]),
      .gt_o          (gt_vec[g]),
      .ge_o          (ge_vec[g])
    );
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= MAX_KEEP)
    else $error("kept list fill beyond depth");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_cnt_q != '0) && (out_cnt_q <= fill_q))
    else $error("drain count out of range");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_of_run) |=> (fill_q == '0) && (item_cnt_q == '0) && in_i.ready)
    else $error("set not cleared after final index");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_o.valid ##1 !out_o.valid)
    else $error("result before item was inserted");
`endif

endmodule
